// ----- sv/ult_pkg.sv -----
`timescale 1ns / 1ps

package ult_pkg;

    // Default sizes of the list storage.
    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Widths of the stream fields and of the capacity register.
    localparam int KIND_W   = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int CAP_W    = 7;
    localparam int OUT_DATA_W = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Request kinds. The fourth code is unused and changes nothing.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RDLAST,
        S_MOVE,
        S_DONE
    } t_state;

endpackage

// ----- sv/unordered_list_table_unit.sv -----
`timescale 1ns / 1ps
// Insert, unused kinds and an empty list go from accept through the execute state to the
// result; search and remove scan the list from index 0 until a match or the last live entry,
// and a successful remove then moves the last entry into the freed slot.
// Throughput: one request at a time, its length set mostly by the scan
// that reads the entry memory through its single read port, one entry per cycle.
// Reset (synchronous, active low) empties the list and sets the capacity to 64.
module unordered_list_table_unit
    import ult_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Capacity register write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CAP_W-1:0]       i_cfg_data,

    // Request stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,   // [31:0] value (signed)
    input  logic [KIND_W-1:0]      s_axis_tuser,   // [1:0] kind

    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [5:0] position, [12:6] entry_count
    output logic [STATUS_W-1:0]    m_axis_tuser    // [1:0] status
);

    // Address width of the entry memory and width of the live count, which must
    // be able to hold DEPTH itself.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    // Common widths used to compare or truncate values of different sizes.
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int PW = (AW > POS_W) ? AW : POS_W;
    localparam int XW = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

    // Entry storage: one write port and one registered read port.
    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]          rd_addr;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;

    t_state                 r_state, n_state;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [CW-1:0]          r_idx, n_idx;
    logic                   r_cmp_valid, n_cmp_valid;
    logic [AW-1:0]          r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]          r_where, n_where;
    logic [CW-1:0]          r_count, n_count;
    logic [CAP_W-1:0]       r_cap, n_cap;
    t_status                r_status, n_status;
    logic [AW-1:0]          r_pos, n_pos;
    logic                   r_out_valid, n_out_valid;
    t_status                r_out_status, n_out_status;
    logic [POS_W-1:0]       r_out_pos, n_out_pos;
    logic [COUNT_W-1:0]     r_out_count, n_out_count;

    logic                   in_fire;
    logic [LW-1:0]          cap_eff;
    logic                   has_room;
    logic [CW-1:0]          last_cnt;
    logic [AW-1:0]          last_idx;
    logic                   hit;
    logic                   scan_end;
    logic [XW-1:0]          val_ext;
    logic [PW-1:0]          pos_ext;
    logic [LW-1:0]          cnt_ext;

    // Always writable; software must write the capacity register only while idle (unchecked).
    assign o_cfg_ready   = 1'b1;
    // A new request is taken whenever the sequencer is idle, even while the previous
    // result still waits in the output register.
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {{(OUT_DATA_W - POS_W - COUNT_W){1'b0}}, r_out_count, r_out_pos};

    // The incoming value is kept in its low VALUE_WIDTH bits.
    assign val_ext = XW'(s_axis_tdata);

    // Effective capacity is the register saturated to DEPTH.
    assign cap_eff  = (LW'(r_cap) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(r_cap);
    assign has_room = LW'(r_count) < cap_eff;

    assign last_cnt = r_count - 1'b1;
    assign last_idx = last_cnt[AW-1:0];

    // Compare stage of the scan: the entry read in the previous cycle against the key.
    assign hit      = r_cmp_valid && (r_rd_data == r_val);
    assign scan_end = r_cmp_valid && (CW'(r_cmp_idx) == last_cnt);

    // Result fields are reduced to the port widths (position modulo 64, count modulo 128).
    assign pos_ext = PW'(r_pos);
    assign cnt_ext = LW'(r_count);

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_val        = r_val;
        n_idx        = r_idx;
        n_cmp_valid  = 1'b0;
        n_cmp_idx    = r_idx[AW-1:0];
        n_where      = r_where;
        n_count      = r_count;
        n_cap        = r_cap;
        n_status     = r_status;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;
        rd_addr      = r_idx[AW-1:0];
        mem_we       = 1'b0;
        mem_waddr    = r_count[AW-1:0];
        mem_wdata    = r_val;

        if (i_cfg_valid) begin
            n_cap = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_kind  = s_axis_tuser;
                    n_val   = val_ext[VALUE_WIDTH-1:0];
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_status = ST_MISSING;
                n_pos    = '0;
                n_idx    = '0;
                n_state  = S_DONE;
                case (r_kind) inside
                    KIND_INSERT: begin
                        if (has_room) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            mem_wdata = r_val;
                            n_pos     = r_count[AW-1:0];
                            n_count   = r_count + 1'b1;
                            n_status  = ST_OK;
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                    KIND_SEARCH, KIND_REMOVE: begin
                        // An empty list has nothing to scan.
                        if (r_count != '0) begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_status = ST_MISSING;
                    end
                endcase
            end

            S_SCAN: begin
                // The compare stage works on the entry read at the previous cycle's read address.
                rd_addr = r_idx[AW-1:0];
                if (hit) begin
                    n_where = r_cmp_idx;
                    n_pos   = r_cmp_idx;
                    if (r_kind == KIND_REMOVE) begin
                        n_state = S_RDLAST;
                    end else begin
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end
                end else if (scan_end) begin
                    n_status = ST_MISSING;
                    n_pos    = '0;
                    n_state  = S_DONE;
                end else if (r_idx < r_count) begin
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_idx[AW-1:0];
                    n_idx       = r_idx + 1'b1;
                end
            end

            S_RDLAST: begin
                rd_addr = last_idx;
                n_state = S_MOVE;
            end

            S_MOVE: begin
                // The last live entry fills the freed slot; it may be the same slot.
                mem_we    = 1'b1;
                mem_waddr = r_where;
                mem_wdata = r_rd_data;
                n_count   = last_cnt;
                n_status  = ST_OK;
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_pos    = pos_ext[POS_W-1:0];
                    n_out_count  = cnt_ext[COUNT_W-1:0];
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_valid <= 1'b0;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= n_cmp_valid;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_where      <= n_where;
        r_status     <= n_status;
        r_pos        <= n_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
    end

    // Entry memory: written at one address, read at one address with registered data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

`ifndef ASSERT_OFF
    // The live count never exceeds the storage depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_count) <= LW'(DEPTH))
        else $error("live count exceeds DEPTH");

    // A successful remove shrinks the list by exactly one entry.
    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |=> (r_count == $past(last_cnt)))
        else $error("remove did not decrement the live count");

    // The scan only compares entries when the list holds something.
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0))
        else $error("scan running on an empty list");

    // A failed request reports position zero.
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata[POS_W-1:0] == '0))
        else $error("nonzero position on a failed request");
`endif

endmodule
